@@ rtl/e2q_pkg.sv @@
// e2q_pkg: shared types and constants for the Euler-angle to quaternion converter
package e2q_pkg;

   localparam int AngleBits   = 16;
   localparam int FracBits    = 14;
   localparam int CordicSteps = 30;
   localparam int CordicWidth = 34;
   localparam logic signed [CordicWidth-1:0] CordicGainInv = 34'sd652032874;

   typedef struct packed {
      logic [AngleBits-1:0] pitch_angle;
      logic [AngleBits-1:0] yaw_angle;
      logic [AngleBits-1:0] roll_angle;
   } req_word_type;

   typedef struct packed {
      logic [FracBits+1:0] quat_x;
      logic [FracBits+1:0] quat_y;
      logic [FracBits+1:0] quat_z;
      logic [FracBits+1:0] quat_w;
   } rsp_word_type;

   function automatic logic signed [33:0] atan_turn(input logic [4:0] step);
      logic signed [33:0] val;
      unique case (step)
         5'd0:  val = 34'sd536870912;
         5'd1:  val = 34'sd316933406;
         5'd2:  val = 34'sd167458907;
         5'd3:  val = 34'sd85004756;
         5'd4:  val = 34'sd42667331;
         5'd5:  val = 34'sd21354465;
         5'd6:  val = 34'sd10679838;
         5'd7:  val = 34'sd5340245;
         5'd8:  val = 34'sd2670163;
         5'd9:  val = 34'sd1335087;
         5'd10: val = 34'sd667544;
         5'd11: val = 34'sd333772;
         5'd12: val = 34'sd166886;
         5'd13: val = 34'sd83443;
         5'd14: val = 34'sd41722;
         5'd15: val = 34'sd20861;
         5'd16: val = 34'sd10430;
         5'd17: val = 34'sd5215;
         5'd18: val = 34'sd2608;
         5'd19: val = 34'sd1304;
         5'd20: val = 34'sd652;
         5'd21: val = 34'sd326;
         5'd22: val = 34'sd163;
         5'd23: val = 34'sd81;
         5'd24: val = 34'sd41;
         5'd25: val = 34'sd20;
         5'd26: val = 34'sd10;
         5'd27: val = 34'sd5;
         5'd28: val = 34'sd3;
         5'd29: val = 34'sd1;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

@@ rtl/e2q_cordic.sv @@
// e2q_cordic: pipelined rotation CORDIC, angle in, sin and cos of half the angle out
module e2q_cordic #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [ANGLE_BITS-1:0]  in_angle,
   output logic                   out_valid,
   output logic signed [31:0]     out_sin,
   output logic signed [31:0]     out_cos
);
   localparam int N = e2q_pkg::CordicSteps;
   localparam int W = e2q_pkg::CordicWidth;

   logic signed [W-1:0] x_ff [N+1];
   logic signed [W-1:0] y_ff [N+1];
   logic signed [W-1:0] z_ff [N+1];
   logic [N:0]          v_ff;
   logic signed [W-1:0] z_in;
   logic signed [32:0]  turn;

   // scale to 2^32 units per turn, then halve with floor
   assign turn = $signed({in_angle, {(33-ANGLE_BITS){1'b0}}}) >>> 1;
   assign z_in = W'(turn >>> 1);

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else v_ff <= {v_ff[N-1:0], in_valid};
      x_ff[0] <= e2q_pkg::CordicGainInv;
      y_ff[0] <= '0;
      z_ff[0] <= z_in;
      for (int i = 0; i < N; i++) begin
         if (!z_ff[i][W-1]) begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - e2q_pkg::atan_turn(5'(i));
         end else begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + e2q_pkg::atan_turn(5'(i));
         end
      end
   end

   assign out_valid = v_ff[N];
   assign out_sin   = 32'(y_ff[N]);
   assign out_cos   = 32'(x_ff[N]);
endmodule

@@ rtl/e2q_combine.sv @@
// e2q_combine: triple products, sums, rounding and saturation
module e2q_combine #(
   parameter int FRAC_BITS = 14
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic signed [31:0]         sp, cp, sy, cy, sr, cr,
   output logic                       out_valid,
   output logic signed [FRAC_BITS+1:0] out_q [4]
);
   localparam int SH = 60 - FRAC_BITS;
   localparam logic signed [63:0] LIM = 64'sd1 <<< FRAC_BITS;

   // stage 1: pair products, Q2.60 -> floor >> 30
   logic signed [63:0] p_in [4];
   logic signed [33:0] p_ff [4];
   logic signed [31:0] c1_ff [2];
   // stage 2: eight triple products
   logic signed [65:0] t_ff [8];
   // stage 3: sums
   logic signed [66:0] s_ff [4];
   logic v_ff [4];

   assign p_in[0] = 64'(sr) * 64'(cp);
   assign p_in[1] = 64'(cr) * 64'(sp);
   assign p_in[2] = 64'(cr) * 64'(cp);
   assign p_in[3] = 64'(sr) * 64'(sp);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0; v_ff[1] <= 1'b0; v_ff[2] <= 1'b0; v_ff[3] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid; v_ff[1] <= v_ff[0];
         v_ff[2] <= v_ff[1]; v_ff[3] <= v_ff[2];
      end
      for (int k = 0; k < 4; k++) p_ff[k] <= 34'(p_in[k] >>> 30);
      c1_ff[0] <= cy; c1_ff[1] <= sy;
      // sr*cp, cr*sp, cr*cp, sr*sp times cy and sy
      for (int k = 0; k < 4; k++) begin
         t_ff[2*k]   <= 66'(p_ff[k]) * 66'(c1_ff[0]);
         t_ff[2*k+1] <= 66'(p_ff[k]) * 66'(c1_ff[1]);
      end
      s_ff[0] <= 67'(t_ff[0]) - 67'(t_ff[3]);   // x
      s_ff[1] <= 67'(t_ff[2]) + 67'(t_ff[1]);   // y
      s_ff[2] <= 67'(t_ff[5]) - 67'(t_ff[6]);   // z
      s_ff[3] <= 67'(t_ff[4]) + 67'(t_ff[7]);   // w
      for (int k = 0; k < 4; k++) begin
         logic signed [66:0] r;
         r = (s_ff[k] + (67'sd1 <<< (SH-1))) >>> SH;
         if (r > 67'(LIM)) out_q[k] <= (FRAC_BITS+2)'(LIM);
         else if (r < -67'(LIM)) out_q[k] <= (FRAC_BITS+2)'(-LIM);
         else out_q[k] <= (FRAC_BITS+2)'(r);
      end
   end

   assign out_valid = v_ff[3];
endmodule

@@ rtl/euler_to_quaternion.sv @@
// euler_to_quaternion: top level of the Euler-angle to quaternion converter
// Takes one word per cycle (busy is never high) and returns each result word
// after one input register, then 30 CORDIC rotation stages in each
// of three parallel lanes (pitch, yaw, roll half angles), then pair-product,
// triple-product, sum and round/saturate stages. rsp_valid pulses for one
// cycle per word; the receiver cannot stall, so words must be taken at once.
// Outputs are Q2.FracBits, saturated to +/- 1.0. Angle and output widths are
// set by the package constants AngleBits and FracBits.
module euler_to_quaternion (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  e2q_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   output e2q_pkg::rsp_word_type rsp_word
);
   logic acc;
   logic v_p, v_y, v_r;
   logic signed [31:0] sp, cp, sy, cy, sr, cr;
   logic signed [e2q_pkg::FracBits+1:0] q [4];

   assign busy = 1'b0;
   assign acc  = start && !busy;

   e2q_cordic #(.ANGLE_BITS(e2q_pkg::AngleBits)) u_pitch (.clock, .reset, .in_valid(acc),
      .in_angle(req_word.pitch_angle), .out_valid(v_p),
      .out_sin(sp), .out_cos(cp));
   e2q_cordic #(.ANGLE_BITS(e2q_pkg::AngleBits)) u_yaw (.clock, .reset, .in_valid(acc),
      .in_angle(req_word.yaw_angle), .out_valid(v_y),
      .out_sin(sy), .out_cos(cy));
   e2q_cordic #(.ANGLE_BITS(e2q_pkg::AngleBits)) u_roll (.clock, .reset, .in_valid(acc),
      .in_angle(req_word.roll_angle), .out_valid(v_r),
      .out_sin(sr), .out_cos(cr));

   e2q_combine #(.FRAC_BITS(e2q_pkg::FracBits)) u_comb (.clock, .reset,
      .in_valid(v_p), .sp, .cp, .sy, .cy, .sr, .cr,
      .out_valid(rsp_valid), .out_q(q));

   assign rsp_word.quat_x = q[0];
   assign rsp_word.quat_y = q[1];
   assign rsp_word.quat_z = q[2];
   assign rsp_word.quat_w = q[3];

   // the three lanes run in lockstep
   a_lanes: assert property (@(posedge clock) disable iff (reset)
      (v_p == v_y) && (v_y == v_r)) else $error("lane valid mismatch");
   // a result word carries no unknown bits
   a_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_word)) else $error("unknown result");
endmodule

@@ tb/tb.sv @@
// tb: self-checking testbench for the Euler-angle to quaternion converter
`timescale 1ns / 100ps

module tb;

   localparam int Latency     = 35;
   localparam int CycleLimit  = 400000;
   localparam int RandomWords = 1050;

   // Phases of idling; the receiver cannot stall, so only the sender idles.
   typedef enum int {
      PHASE_BUSY_SEND,
      PHASE_IDLE_51,
      PHASE_IDLE_6
   } phase_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   e2q_pkg::req_word_type req_word;
   logic                  rsp_valid;
   e2q_pkg::rsp_word_type rsp_word;

   int mismatch_count;
   int cycle_count;

   euler_to_quaternion dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_word(rsp_word)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   task automatic report_mismatch(input string what);
      $display("error at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   // Predicts quaternion words and holds them in arrival order.
   class quat_scoreboard;
      e2q_pkg::rsp_word_type quat_queue[$];

      static function longint floor_shr(longint v, int s);
         return v >>> s;
      endfunction

      // Sine and cosine of half a 16-bit binary angle, Q1.30 CORDIC.
      static function void half_sin_cos(logic [15:0] raw, output longint sn,
                                        output longint cs);
         longint t, z, x, y, dx, dy;
         t = longint'($signed(raw)) * 65536;
         z = t / 2;
         x = 652032874;
         y = 0;
         for (int i = 0; i < 30; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0) begin
               x -= dx;
               y += dy;
               z -= longint'(e2q_pkg::atan_turn(i[4:0]));
            end else begin
               x += dx;
               y -= dy;
               z += longint'(e2q_pkg::atan_turn(i[4:0]));
            end
         end
         sn = y;
         cs = x;
      endfunction

      static function longint tri_prod(longint a, longint b, longint c);
         return floor_shr(a * b, 30) * c;
      endfunction

      // Q2.60 sum to Q2.14, round half up, saturate at +/- 1.0.
      static function logic [15:0] round_sat(longint s);
         longint r;
         r = floor_shr(s + (longint'(1) <<< 45), 46);
         if (r > 16384) r = 16384;
         if (r < -16384) r = -16384;
         return r[15:0];
      endfunction

      function void note_angles(e2q_pkg::req_word_type w);
         longint sp, cp, sy, cy, sr, cr;
         e2q_pkg::rsp_word_type q;
         half_sin_cos(w.pitch_angle, sp, cp);
         half_sin_cos(w.yaw_angle, sy, cy);
         half_sin_cos(w.roll_angle, sr, cr);
         q.quat_x = round_sat(tri_prod(sr, cp, cy) - tri_prod(cr, sp, sy));
         q.quat_y = round_sat(tri_prod(cr, sp, cy) + tri_prod(sr, cp, sy));
         q.quat_z = round_sat(tri_prod(cr, cp, sy) - tri_prod(sr, sp, cy));
         q.quat_w = round_sat(tri_prod(cr, cp, cy) + tri_prod(sr, sp, sy));
         quat_queue.push_back(q);
      endfunction

      task check_quat(e2q_pkg::rsp_word_type got);
         e2q_pkg::rsp_word_type want;
         if (quat_queue.size() == 0) begin
            report_mismatch($sformatf("unexpected word %h", got));
            return;
         end
         want = quat_queue.pop_front();
         if (got.quat_x !== want.quat_x)
            report_mismatch($sformatf("x got %h want %h", got.quat_x, want.quat_x));
         if (got.quat_y !== want.quat_y)
            report_mismatch($sformatf("y got %h want %h", got.quat_y, want.quat_y));
         if (got.quat_z !== want.quat_z)
            report_mismatch($sformatf("z got %h want %h", got.quat_z, want.quat_z));
         if (got.quat_w !== want.quat_w)
            report_mismatch($sformatf("w got %h want %h", got.quat_w, want.quat_w));
      endtask
   endclass

   quat_scoreboard quat_board = new();
   int idle_pct;

   // Accepted inputs are noted and results checked at the rising edge.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (start && !busy) quat_board.note_angles(req_word);
         if (rsp_valid) quat_board.check_quat(rsp_word);
      end
   end

   // Drive one word: wait out random idling, then hold start until accepted.
   task automatic send_angles(input logic [15:0] p, input logic [15:0] y,
                              input logic [15:0] r);
      while (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_word <= '{pitch_angle: p, yaw_angle: y, roll_angle: r};
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_quats();
      start <= 1'b0;
      while (quat_board.quat_queue.size() != 0) @(negedge clock);
   endtask

   // Random angle: mostly full-range, sometimes near a notable point.
   function automatic logic [15:0] pick_angle();
      logic [15:0] base;
      case ($urandom_range(3, 0))
         0: base = 16'h0000;
         1: base = 16'h4000;
         2: base = 16'h8000;
         default: base = 16'hC000;
      endcase
      if ($urandom_range(3, 0) == 0)
         return base + 16'($signed($urandom_range(8, 0)) - 4);
      return 16'($urandom());
   endfunction

   initial begin
      logic [15:0] edge_angles[10];
      phase_type phase;
      edge_angles = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001,
                      16'h4000, 16'hC000, 16'h2000, 16'hE000, 16'h5555};
      mismatch_count = 0;
      idle_pct = 0;
      reset = 1'b1;
      start = 1'b0;
      req_word = '0;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      // Directed: each field alone at its extremes and notable points,
      // then all together (full-turn extremes push components to +/- 1.0).
      for (int i = 0; i < 10; i++) begin
         send_angles(edge_angles[i], 16'h0000, 16'h0000);
         send_angles(16'h0000, edge_angles[i], 16'h0000);
         send_angles(16'h0000, 16'h0000, edge_angles[i]);
      end
      send_angles(16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_angles(16'h8000, 16'h8000, 16'h8000);
      send_angles(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_angles(16'h4000, 16'hC000, 16'h2000);
      send_angles(16'h5555, 16'hAAAA, 16'hE000);

      // Pause until everything is back before the random part.
      drain_quats();

      for (int n = 0; n < RandomWords; n++) begin
         phase = phase_type'((n / 175) % 3);
         case (phase)
            PHASE_BUSY_SEND: idle_pct = 0;
            PHASE_IDLE_51:   idle_pct = 51;
            default:         idle_pct = 6;
         endcase
         send_angles(pick_angle(), pick_angle(), pick_angle());
      end

      drain_quats();
      repeat (Latency + 5) @(negedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      if (cycle_count > CycleLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

endmodule
